// ===== rtl/page_table_frame_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// page_table_frame_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGE_TABLE_FRAME_ALLOCATOR_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define PTFA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define PTFA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptfa_pkg.sv =====
// ----------------------------------------------------------------------------
// ptfa_pkg
// Types and codes for the page table and frame allocator.
// ----------------------------------------------------------------------------
package ptfa_pkg;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FRAME_W  = 6;
    localparam int CFG_W    = 7;
    localparam int VA_W     = 32;

    // one frame cell per frame number that the frame field can carry
    localparam int FRAMES   = 64;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [FRAME_W-1:0]  frame_t;
    typedef logic [CFG_W-1:0]    cfg_t;

    localparam mode_t MODE_LOOKUP = 2'd0;
    localparam mode_t MODE_MAP    = 2'd1;
    localparam mode_t MODE_ALLOC  = 2'd2;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_NO_FRAME  = 2'd2;

    localparam cfg_t FRAMES_IN_USE_RESET = 7'd64;

    // search token walking the cell chain
    typedef struct packed {
        logic   valid;
        logic   found;
        frame_t frame;
    } token_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_RUN
    } state_t;

endpackage

// ===== rtl/ptfa_req_if.sv =====
// ----------------------------------------------------------------------------
// ptfa_req_if
// Request channel: mode, virtual address and frame to map.
// ----------------------------------------------------------------------------
interface ptfa_req_if import ptfa_pkg::*; ();

    logic               valid;
    logic               ready;
    mode_t              mode;
    logic [VA_W-1:0]    vaddr;
    frame_t             map_frame;

    modport source (output valid, mode, vaddr, map_frame, input ready);
    modport sink   (input valid, mode, vaddr, map_frame, output ready);

endinterface

// ===== rtl/ptfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ptfa_rsp_if
// Result channel: status, hit flag, frame and physical address.
// ----------------------------------------------------------------------------
interface ptfa_rsp_if import ptfa_pkg::*; ();

    logic               valid;
    logic               ready;
    status_t            status;
    logic               hit;
    frame_t             frame;
    logic [VA_W-1:0]    physical_address;

    modport source (output valid, status, hit, frame, physical_address, input ready);
    modport sink   (input valid, status, hit, frame, physical_address, output ready);

endinterface

// ===== rtl/ptfa_frame_cell.sv =====
// ----------------------------------------------------------------------------
// ptfa_frame_cell
// One frame occupancy flag; claims the frame for a passing allocate token.
// ----------------------------------------------------------------------------
module ptfa_frame_cell
    import ptfa_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  mode_t  mode,
    input  cfg_t   frames_in_use,
    input  token_t tin,
    output token_t tout
);

    localparam logic [31:0] IDX_V = 32'(IDX);

    logic   occ_reg;
    token_t tout_reg;
    token_t tout_next;
    logic   eligible;
    logic   take;

    assign eligible = (32'(frames_in_use) > IDX_V);
    assign take     = tin.valid && (mode == MODE_ALLOC) && !tin.found && eligible && !occ_reg;

    always_comb
    begin
        tout_next = tin;
        if (take)
        begin
            tout_next.found = 1'b1;
            tout_next.frame = FRAME_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            tout_reg <= '0;
        end
        else if (adv)
        begin
            tout_reg <= tout_next;
            if (take)
            begin
                occ_reg <= 1'b1;
            end
        end
    end

    assign tout = tout_reg;

endmodule

// ===== rtl/ptfa_entry_cell.sv =====
// ----------------------------------------------------------------------------
// ptfa_entry_cell
// One page table entry; matches lookups, takes maps, gives up its frame
// to an allocate that found no free frame.
// ----------------------------------------------------------------------------
module ptfa_entry_cell
    import ptfa_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int PAGE_W = 20,
    parameter int SLOT_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  mode_t             mode,
    input  logic [PAGE_W-1:0] page,
    input  logic [SLOT_W-1:0] slot,
    input  frame_t            fidx,
    input  token_t            tin,
    output token_t            tout
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic              valid_reg;
    logic [PAGE_W-1:0] page_reg;
    frame_t            frame_reg;
    token_t            tout_reg;
    token_t            tout_next;
    logic              match;
    logic              evict;
    logic              wr;

    assign match = tin.valid && (mode == MODE_LOOKUP) && !tin.found && valid_reg
                   && (page_reg == page);
    assign evict = tin.valid && (mode == MODE_ALLOC) && !tin.found && valid_reg;
    assign wr    = tin.valid && (mode == MODE_MAP) && (slot == MY_SLOT);

    always_comb
    begin
        tout_next = tin;
        if (match || evict)
        begin
            tout_next.found = 1'b1;
            tout_next.frame = frame_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tout_reg  <= '0;
        end
        else if (adv)
        begin
            tout_reg <= tout_next;
            if (wr)
            begin
                valid_reg <= 1'b1;
            end
            else if (evict)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && wr)
        begin
            page_reg  <= page;
            frame_reg <= fidx;
        end
    end

    assign tout = tout_reg;

endmodule

// ===== rtl/page_table_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// page_table_frame_allocator
// Page table with frame allocator built as a chain of frame and entry cells.
// ----------------------------------------------------------------------------
// One item is in flight at a time. An accepted item launches a search token
// that walks FRAMES frame cells and then ENTRIES entry cells, one cell per
// clock while the chain is not stalled, and the result is registered at the
// end of the chain. When ENTRIES is not a power of two, a map first passes
// through ST_MOD, finding its slot by a reciprocal multiplication and one
// correcting subtract. The next item is accepted as soon as the result is in
// the output register; the chain stalls only if that result is still not
// taken when the next token reaches the end. Configuration writes take
// effect at once and must come only while no item is in flight.
`include "page_table_frame_allocator_defines.svh"

module page_table_frame_allocator
    import ptfa_pkg::*;
#(
    parameter int ENTRIES   = 256,
    parameter int PAGE_BITS = 12
)
(
    input  logic       clk,
    input  logic       rst_n,
    ptfa_req_if.sink   req,
    ptfa_rsp_if.source rsp,
    input  logic       cfg_we,
    input  cfg_t       cfg_wdata
);

    localparam int  PAGE_W = VA_W - PAGE_BITS;
    localparam int  SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int  CNT_W  = 1;
    localparam int  CHAIN  = FRAMES + ENTRIES;
    localparam bit  POW2   = ((ENTRIES & (ENTRIES - 1)) == 0);
    localparam logic [SLOT_W:0]   ENTRIES_V = (SLOT_W + 1)'(ENTRIES);
    localparam logic [PAGE_W-1:0] ENTRIES_P = PAGE_W'(ENTRIES);
    // floor(2^PAGE_W / ENTRIES): the quotient estimate is low by at most one
    localparam logic [PAGE_W-1:0] RECIP = PAGE_W'((64'd1 << PAGE_W) / 64'(ENTRIES));

    state_t               state_reg;
    state_t               state_next;
    cfg_t                 frames_in_use_reg;
    mode_t                mode_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [PAGE_BITS-1:0] offset_reg;
    frame_t               fidx_reg;
    logic                 launch_reg;
    logic                 launch_next;

    logic [2*PAGE_W-1:0]  recip_prod;
    logic [PAGE_W-1:0]    quot_reg;
    logic [PAGE_W-1:0]    rem_wide;
    logic [SLOT_W:0]      rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SLOT_W-1:0]    slot;

    logic                 rsp_valid_reg;
    status_t              status_reg;
    logic                 hit_reg;
    frame_t               frame_reg;
    logic [VA_W-1:0]      pa_reg;
    status_t              status_next;
    logic                 hit_next;
    frame_t               frame_next;
    logic [VA_W-1:0]      pa_next;

    logic                 accept;
    logic                 mod_step;
    logic                 load;
    logic                 adv;
    logic                 req_ready;

    token_t               tok [CHAIN+1];
    token_t               tail;
    logic [CHAIN:0]       tok_valid;

    // ---------------- handshake and control ----------------
    assign tail      = tok[CHAIN];
    assign adv       = !(tail.valid && rsp_valid_reg && !rsp.ready);
    assign accept    = req.valid && req_ready;
    assign req.ready = req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (!POW2 && (req.mode == MODE_MAP)) ? ST_MOD : ST_RUN;
                end
            end
            ST_MOD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tail.valid && adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        mod_step  = 1'b0;
        load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: req_ready = 1'b1;
            ST_MOD:  mod_step  = 1'b1;
            ST_RUN:  load      = tail.valid && adv;
            default: req_ready = 1'b0;
        endcase
    end

    assign launch_next = (state_reg != ST_RUN) && (state_next == ST_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            launch_reg        <= 1'b0;
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
            rsp_valid_reg     <= 1'b0;
            cnt_reg           <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= load || (rsp_valid_reg && !rsp.ready);
            if (cfg_we)
            begin
                frames_in_use_reg <= cfg_wdata;
            end
            if (accept)
            begin
                cnt_reg <= CNT_W'(1);
            end
            else if (mod_step)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= req.mode;
            page_reg   <= req.vaddr[VA_W-1:PAGE_BITS];
            offset_reg <= req.vaddr[PAGE_BITS-1:0];
            fidx_reg   <= req.map_frame;
        end
        else if (mod_step)
        begin
            if (cnt_reg != '0)
            begin
                quot_reg <= recip_prod[2*PAGE_W-1:PAGE_W];
            end
            else
            begin
                rem_reg <= rem_wide[SLOT_W:0];
            end
        end
    end

    // ---------------- slot = page mod ENTRIES ----------------
    // first the quotient estimate, then the remainder in [0, 2*ENTRIES)
    assign recip_prod = (2*PAGE_W)'(page_reg) * (2*PAGE_W)'(RECIP);
    assign rem_wide   = page_reg - quot_reg * ENTRIES_P;
    assign slot       = POW2 ? page_reg[SLOT_W-1:0]
                      : (rem_reg >= ENTRIES_V) ? SLOT_W'(rem_reg - ENTRIES_V)
                                               : SLOT_W'(rem_reg);

    // ---------------- cell chain ----------------
    assign tok[0] = '{valid: launch_reg, found: 1'b0, frame: '0};

    for (genvar j = 0; j < FRAMES; j++)
    begin : g_frame
        ptfa_frame_cell #(
            .IDX (j)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .adv           (adv),
            .mode          (mode_reg),
            .frames_in_use (frames_in_use_reg),
            .tin           (tok[j]),
            .tout          (tok[j+1])
        );
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_entry
        ptfa_entry_cell #(
            .IDX    (i),
            .PAGE_W (PAGE_W),
            .SLOT_W (SLOT_W)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .mode  (mode_reg),
            .page  (page_reg),
            .slot  (slot),
            .fidx  (fidx_reg),
            .tin   (tok[FRAMES+i]),
            .tout  (tok[FRAMES+i+1])
        );
    end

    for (genvar k = 0; k <= CHAIN; k++)
    begin : g_tv
        assign tok_valid[k] = tok[k].valid;
    end

    // ---------------- result ----------------
    always_comb
    begin
        status_next = STATUS_OK;
        hit_next    = 1'b0;
        frame_next  = '0;
        pa_next     = '0;
        unique case (mode_reg)
            MODE_LOOKUP:
            begin
                if (tail.found)
                begin
                    hit_next   = 1'b1;
                    frame_next = tail.frame;
                    pa_next    = VA_W'({tail.frame, offset_reg});
                end
                else
                begin
                    status_next = STATUS_NOT_FOUND;
                    pa_next     = '1;
                end
            end
            MODE_MAP:
            begin
                frame_next = fidx_reg;
            end
            MODE_ALLOC:
            begin
                if (tail.found)
                begin
                    frame_next = tail.frame;
                end
                else
                begin
                    status_next = STATUS_NO_FRAME;
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
            frame_reg  <= frame_next;
            pa_reg     <= pa_next;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.hit              = hit_reg;
    assign rsp.frame            = frame_reg;
    assign rsp.physical_address = pa_reg;

    // ---------------- assertions ----------------
    `PTFA_ASSERT_ALWAYS(a_one_token, clk, rst_n, $onehot0(tok_valid),
        "more than one search token in the chain")
    `PTFA_ASSERT_IMPLY(a_token_in_run, clk, rst_n, |tok_valid, state_reg == ST_RUN,
        "search token in flight outside the run state")
    `PTFA_ASSERT_IMPLY(a_run_has_token, clk, rst_n, state_reg == ST_RUN, |tok_valid,
        "run state with no search token")

endmodule
